>>> rtl/imhq_pkg.sv
// Package with shared types, codes and constants of the indexed min-heap queue.
package imhq_pkg;

   localparam int CAPACITY_DEFAULT = 1024;
   localparam int KEY_BITS_DEFAULT = 32;
   localparam int VERTEX_BITS = 10;
   localparam int VERTEX_SLOTS = 1 << VERTEX_BITS;
   localparam int FIELD_KEY_BITS = 32;
   localparam int ENTRIES_BITS = 11;
   localparam int CMD_DEPTH = 2;

   typedef enum logic [1:0] {
      ACT_INSERT   = 2'd0,
      ACT_EXTRACT  = 2'd1,
      ACT_DECREASE = 2'd2,
      ACT_PEEK     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      action_type               action;
      logic [VERTEX_BITS-1:0]   vertex;
      logic [FIELD_KEY_BITS-1:0] key_value;
   } req_type;

   typedef struct packed {
      logic [VERTEX_BITS-1:0]    out_vertex;
      logic [FIELD_KEY_BITS-1:0] out_key;
      status_type                status;
      logic [ENTRIES_BITS-1:0]   entries;
   } rsp_type;

endpackage

>>> rtl/imhq_front.sv
// Front end: accepts request beats into a short command queue.
module imhq_front #(
   parameter int DEPTH = imhq_pkg::CMD_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  imhq_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_take,
   output imhq_pkg::req_type cmd_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   imhq_pkg::req_type slots_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full      = (cnt_ff == (AW+1)'(DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = slots_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      wr_in  = do_push ? ((wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? ((rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) slots_ff[wr_ff] <= req_data;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH)) else $error("command queue overflow");
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("command queue count lost a push");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      do_pop && !do_push |=> cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("command queue count lost a pop");
endmodule

>>> rtl/imhq_back.sv
// Back end: heap memory, position map and the sift sequencer.
module imhq_back #(
   parameter int CAPACITY = imhq_pkg::CAPACITY_DEFAULT,
   parameter int KEY_BITS = imhq_pkg::KEY_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  imhq_pkg::req_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_take,
   output imhq_pkg::rsp_type rsp_data
);
   localparam int SW = $clog2(CAPACITY);
   localparam int CW = SW + 1;
   localparam int VB = imhq_pkg::VERTEX_BITS;
   localparam int FK = imhq_pkg::FIELD_KEY_BITS;
   localparam int EW = imhq_pkg::ENTRIES_BITS;

   typedef struct packed {
      logic [VB-1:0]       vertex;
      logic [KEY_BITS-1:0] key;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE, S_RD0, S_RD1, S_EXT, S_UP_RD, S_UP_CMP,
      S_DN_RD, S_DN_L, S_DN_R, S_DN_CMP, S_DEC, S_DONE
   } state_type;

   entry_type heap_mem [CAPACITY];
   logic [SW-1:0] pos_mem [imhq_pkg::VERTEX_SLOTS];

   state_type      state_ff;
   logic [CW-1:0]  count_ff;
   logic [SW-1:0]  cur_ff, oth_ff;
   entry_type      cur_e_ff, rd_e_ff, left_e_ff;
   logic           left_ok_ff;
   logic [SW-1:0]  mapped_ff;
   imhq_pkg::req_type cmd_ff;
   imhq_pkg::rsp_type rsp_ff;
   logic              rsp_v_ff;

   logic [SW-1:0] raddr;
   logic          hwe;
   logic [SW-1:0] waddr;
   entry_type     wdata;
   logic          pwe;
   logic [VB-1:0] paddr;
   logic [SW-1:0] pdata;

   logic [CW:0] lidx, ridx;
   logic [CW-1:0] last_idx;
   logic [KEY_BITS-1:0] kin;

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;
   assign cmd_take  = (state_ff == S_IDLE) && !rsp_v_ff;
   assign lidx = (CW+1)'({cur_ff, 1'b1});
   assign ridx = {cur_ff, 1'b0} + (CW+1)'(2);
   assign last_idx = count_ff - 1'b1;
   assign kin  = KEY_BITS'(cmd_data.key_value);

   always_ff @(posedge clock) begin
      rd_e_ff   <= heap_mem[raddr];
      mapped_ff <= pos_mem[cmd_data.vertex];
      if (hwe) heap_mem[waddr] <= wdata;
      if (pwe) pos_mem[paddr] <= pdata;
   end

   function automatic logic [FK-1:0] key_out(input logic [KEY_BITS-1:0] k);
      logic [FK+KEY_BITS-1:0] w;
      w = {{FK{1'b0}}, k};
      return w[FK-1:0];
   endfunction

   always_comb begin
      raddr = '0;
      hwe = 1'b0; waddr = cur_ff; wdata = cur_e_ff;
      pwe = 1'b0; paddr = cur_e_ff.vertex; pdata = cur_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_take && cmd_valid && cmd_data.action == imhq_pkg::ACT_INSERT
                && count_ff != CW'(CAPACITY)) begin
               hwe = 1'b1; waddr = count_ff[SW-1:0];
               wdata = '{vertex: cmd_data.vertex, key: kin};
               pwe = 1'b1; paddr = cmd_data.vertex; pdata = count_ff[SW-1:0];
            end
            raddr = '0;
         end
         S_RD0: raddr = last_idx[SW-1:0];
         S_UP_RD: raddr = oth_ff;
         S_UP_CMP: begin
            hwe = 1'b1; pwe = 1'b1;
            if (cur_ff != '0 && rd_e_ff.key > cur_e_ff.key) begin
               wdata = rd_e_ff;
               paddr = rd_e_ff.vertex;
            end
         end
         S_DN_RD: raddr = lidx[SW-1:0];
         S_DN_L: raddr = ridx[SW-1:0];
         S_DN_CMP: begin
            hwe = 1'b1; pwe = 1'b1;
            if (oth_ff != cur_ff) begin
               wdata = left_e_ff;
               paddr = left_e_ff.vertex;
            end
         end
         S_DEC: raddr = mapped_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (rsp_v_ff && rsp_take) rsp_v_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (cmd_take && cmd_valid) begin
               cmd_ff <= cmd_data;
               rsp_ff.out_vertex <= '0;
               rsp_ff.out_key <= '0;
               unique case (cmd_data.action)
                  imhq_pkg::ACT_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        rsp_ff.status <= imhq_pkg::ST_FULL;
                        state_ff <= S_DONE;
                     end else begin
                        rsp_ff.status <= imhq_pkg::ST_OK;
                        cur_ff <= count_ff[SW-1:0];
                        cur_e_ff <= '{vertex: cmd_data.vertex, key: kin};
                        count_ff <= count_ff + 1'b1;
                        state_ff <= S_UP_RD;
                     end
                  end
                  imhq_pkg::ACT_DECREASE: begin
                     rsp_ff.status <= imhq_pkg::ST_OK;
                     state_ff <= S_DEC;
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_ff.status <= imhq_pkg::ST_EMPTY;
                        state_ff <= S_DONE;
                     end else begin
                        rsp_ff.status <= imhq_pkg::ST_OK;
                        state_ff <= S_RD0;
                     end
                  end
               endcase
               oth_ff <= (count_ff[SW-1:0] - 1'b1) >> 1;
            end
            S_RD0: begin
               rsp_ff.out_vertex <= rd_e_ff.vertex;
               rsp_ff.out_key <= key_out(rd_e_ff.key);
               if (cmd_ff.action == imhq_pkg::ACT_PEEK) state_ff <= S_DONE;
               else begin
                  count_ff <= count_ff - 1'b1;
                  state_ff <= S_EXT;
               end
            end
            S_EXT: begin
               cur_ff <= '0;
               cur_e_ff <= rd_e_ff;
               state_ff <= S_DN_RD;
            end
            S_UP_RD: begin
               if (cur_ff == '0) state_ff <= S_UP_CMP;
               else state_ff <= S_UP_CMP;
            end
            S_UP_CMP: begin
               if (cur_ff != '0 && rd_e_ff.key > cur_e_ff.key) begin
                  cur_ff <= oth_ff;
                  oth_ff <= (oth_ff - 1'b1) >> 1;
                  state_ff <= S_UP_RD;
               end else state_ff <= S_DONE;
            end
            S_DN_RD: state_ff <= S_DN_L;
            S_DN_L: begin
               left_e_ff <= rd_e_ff;
               left_ok_ff <= ((CW+1)'(count_ff) > lidx);
               state_ff <= S_DN_R;
            end
            S_DN_R: begin
               priority if ((CW+1)'(count_ff) > ridx &&
                            rd_e_ff.key < ((left_ok_ff && left_e_ff.key < cur_e_ff.key)
                                           ? left_e_ff.key : cur_e_ff.key)) begin
                  oth_ff <= ridx[SW-1:0];
                  left_e_ff <= rd_e_ff;
                  state_ff <= S_DN_CMP;
               end else if (left_ok_ff && left_e_ff.key < cur_e_ff.key) begin
                  oth_ff <= lidx[SW-1:0];
                  state_ff <= S_DN_CMP;
               end else begin
                  oth_ff <= cur_ff;
                  state_ff <= S_DN_CMP;
               end
            end
            S_DN_CMP: begin
               if (oth_ff == cur_ff) state_ff <= S_DONE;
               else begin
                  cur_ff <= oth_ff;
                  state_ff <= S_DN_RD;
               end
            end
            S_DEC: begin
               cur_ff <= mapped_ff;
               state_ff <= S_RD1;
            end
            S_RD1: begin
               if (CW'(cur_ff) < count_ff && rd_e_ff.vertex == cmd_ff.vertex
                   && KEY_BITS'(cmd_ff.key_value) <= rd_e_ff.key) begin
                  cur_e_ff <= '{vertex: rd_e_ff.vertex,
                                key: KEY_BITS'(cmd_ff.key_value)};
                  oth_ff <= (cur_ff - 1'b1) >> 1;
                  state_ff <= S_UP_RD;
               end else state_ff <= S_DONE;
            end
            S_DONE: begin
               rsp_ff.entries <= EW'(count_ff);
               rsp_v_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("entry count above capacity");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> state_ff == S_IDLE && !rsp_v_ff) else $error("take while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> rsp_v_ff) else $error("result not raised");
endmodule

>>> rtl/indexed_min_heap_queue_unit.sv
// Top level of the indexed min-heap priority queue.
// Requests are written like a queue: a beat is taken when req_push is high and
// req_full is low. Each request is insert, extract minimum, decrease key or peek.
// Every request gives one response beat, read like a queue: the oldest response
// waits on rsp_data while rsp_empty is low and leaves when rsp_pop is high.
// A two-entry command queue sits in front of the heap sequencer, so requests are
// taken while a response waits to be popped.
// Insert and decrease climb the heap level by level, and extract sinks level by
// level; the heap memory gives one read a cycle from its single read port, beside
// a separate write port.
// The sequencer takes the next request only after the response has been popped,
// so it works on one request at a time.
// Reset empties the heap; heap and map contents stay undefined until written.
// When the receiver stalls, one response is held and further requests queue up
// until the command queue is full, then req_full rises.
module indexed_min_heap_queue_unit #(
   parameter int CAPACITY = imhq_pkg::CAPACITY_DEFAULT,
   parameter int KEY_BITS = imhq_pkg::KEY_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  imhq_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output imhq_pkg::rsp_type rsp_data
);
   logic cmd_valid, cmd_take, rsp_valid;
   imhq_pkg::req_type cmd_data;

   imhq_front #(.DEPTH(imhq_pkg::CMD_DEPTH)) u_front (
      .clock, .reset, .push(req_push), .full(req_full), .req_data,
      .cmd_valid, .cmd_take, .cmd_data
   );

   imhq_back #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd_data,
      .rsp_valid, .rsp_take(rsp_pop), .rsp_data
   );

   assign rsp_empty = !rsp_valid;
endmodule
